[hw/rtl/rfft_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rfft_pkg;

   localparam int MAX_LOG2     = 10;
   localparam int SAMPLE_BITS  = 16;
   localparam int TWIDDLE_BITS = 16;
   localparam int WORD_BITS    = 27;
   localparam int AW           = MAX_LOG2;
   localparam int TW_AW        = MAX_LOG2 - 1;
   localparam int TW_DEPTH     = 1 << TW_AW;
   localparam int PROD_BITS    = WORD_BITS + TWIDDLE_BITS + 1;
   localparam int SUM_BITS     = PROD_BITS + 1;
   localparam int L_BITS       = $clog2(MAX_LOG2 + 1);
   localparam logic [63:0] PI_Q    = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic [AW-1:0]                  addr;
      logic [AW-1:0]                  index;
      logic signed [SAMPLE_BITS-1:0]  re;
      logic signed [SAMPLE_BITS-1:0]  im;
   } cmd_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } bfly_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_BF_READ,
      ST_BF_MUL,
      ST_BF_SUM,
      ST_BF_WR_A,
      ST_BF_WR_B,
      ST_SC_READ,
      ST_SC_WR
   } back_state_type;

   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
      lo = -hi - SUM_BITS'(1);
      if (v > hi) begin
         return hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // Builds the twiddle table from a fixed-point Taylor series at elaboration.
   function automatic logic [TW_DEPTH*TWIDDLE_BITS-1:0] build_tw(input logic is_sin);
      logic [TW_DEPTH*TWIDDLE_BITS-1:0] tab;
      logic [127:0] p;
      logic [63:0]  f, x, x2, term, pos, neg, mag, r, lim;
      logic         minus;
      tab = '0;
      for (int k = 0; k < TW_DEPTH; k++) begin
         f = MAX_LOG2 > 1 ? (64'(k) << (65 - MAX_LOG2)) : 64'd0;
         p = {64'd0, PI_Q} * {64'd0, f};
         x = p[127:64];
         p = {64'd0, x} * {64'd0, x};
         x2 = p[123:60];
         if (!is_sin) begin
            term = ONE_Q60;
            pos = ONE_Q60;
            neg = 64'd0;
            for (int n = 1; n <= 40; n++) begin
               p = {64'd0, term} * {64'd0, x2};
               term = p[123:60] / 64'((2 * n - 1) * (2 * n));
               if (n % 2 == 1) neg = neg + term; else pos = pos + term;
            end
         end else begin
            term = x;
            neg = x;
            pos = 64'd0;
            for (int n = 1; n <= 40; n++) begin
               p = {64'd0, term} * {64'd0, x2};
               term = p[123:60] / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) pos = pos + term; else neg = neg + term;
            end
         end
         minus = neg > pos;
         mag = minus ? neg - pos : pos - neg;
         lim = 64'd1 << (TWIDDLE_BITS - 1);
         r = (mag + (64'd1 << (60 - TWIDDLE_BITS))) >> (61 - TWIDDLE_BITS);
         if (minus) begin
            r = (r > lim) ? (64'd0 - lim) : (64'd0 - r);
         end else begin
            r = (r > lim - 64'd1) ? (lim - 64'd1) : r;
         end
         tab[k*TWIDDLE_BITS +: TWIDDLE_BITS] = r[TWIDDLE_BITS-1:0];
      end
      return tab;
   endfunction

   localparam logic [TW_DEPTH*TWIDDLE_BITS-1:0] TW_COS = build_tw(1'b0);
   localparam logic [TW_DEPTH*TWIDDLE_BITS-1:0] TW_SIN = build_tw(1'b1);

endpackage
`default_nettype wire

[hw/rtl/rfft_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfft_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_func,
   input  wire logic [rfft_pkg::AW-1:0]               req_sample_index,
   input  wire logic signed [rfft_pkg::SAMPLE_BITS-1:0] req_sample_re,
   input  wire logic signed [rfft_pkg::SAMPLE_BITS-1:0] req_sample_im,
   input  wire logic [rfft_pkg::L_BITS-1:0]           eff_l,
   output logic                                       cmd_valid,
   output rfft_pkg::cmd_type                          cmd,
   input  wire logic                                  cmd_pop
);
   import rfft_pkg::*;

   cmd_type       q_ff [2];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push;
   logic [AW-1:0] mask, idx, rev;
   cmd_type       item;

   always_comb begin
      mask = AW'((11'd1 << eff_l) - 11'd1);
      idx = req_sample_index & mask;
      for (int b = 0; b < AW; b++) begin
         rev[b] = idx[AW-1-b];
      end
      rev = rev >> (AW - eff_l);
      item.index = idx;
      item.re = req_sample_re;
      item.im = req_sample_im;
      item.addr = idx;
      item.op = OP_READ;
      case (req_func)
         OP_LOAD: begin
            item.op = OP_LOAD;
            item.addr = rev;
         end
         OP_RUN:  item.op = OP_RUN;
         default: item.op = OP_READ;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall && (req_func inside {OP_LOAD, OP_RUN, OP_READ});
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rp_ff];

   always_comb begin
      wp_in = push ? !wp_ff : wp_ff;
      rp_in = cmd_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= item;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rfft_bfly.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfft_bfly (
   input  wire logic                                    clock,
   input  wire rfft_pkg::bfly_ctl_type                  ctl,
   input  wire logic signed [rfft_pkg::WORD_BITS-1:0]    a_re,
   input  wire logic signed [rfft_pkg::WORD_BITS-1:0]    a_im,
   input  wire logic signed [rfft_pkg::WORD_BITS-1:0]    b_re,
   input  wire logic signed [rfft_pkg::WORD_BITS-1:0]    b_im,
   input  wire logic signed [rfft_pkg::TWIDDLE_BITS:0]   w_re,
   input  wire logic signed [rfft_pkg::TWIDDLE_BITS:0]   w_im,
   output logic signed [rfft_pkg::WORD_BITS-1:0]         top_re,
   output logic signed [rfft_pkg::WORD_BITS-1:0]         top_im,
   output logic signed [rfft_pkg::WORD_BITS-1:0]         bot_re,
   output logic signed [rfft_pkg::WORD_BITS-1:0]         bot_im
);
   import rfft_pkg::*;

   logic signed [PROD_BITS-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [WORD_BITS-1:0] ar_ff, ai_ff, ar2_ff, ai2_ff, tr_ff, ti_ff;
   logic signed [SUM_BITS-1:0]  sr, si;

   always_comb begin
      sr = (SUM_BITS'(p_rr_ff) - SUM_BITS'(p_ii_ff)
            + (SUM_BITS'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
      si = (SUM_BITS'(p_ri_ff) + SUM_BITS'(p_ir_ff)
            + (SUM_BITS'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
      top_re = sat_word(SUM_BITS'(ar2_ff) + SUM_BITS'(tr_ff));
      top_im = sat_word(SUM_BITS'(ai2_ff) + SUM_BITS'(ti_ff));
      bot_re = sat_word(SUM_BITS'(ar2_ff) - SUM_BITS'(tr_ff));
      bot_im = sat_word(SUM_BITS'(ai2_ff) - SUM_BITS'(ti_ff));
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         p_rr_ff <= PROD_BITS'(w_re * b_re);
         p_ii_ff <= PROD_BITS'(w_im * b_im);
         p_ri_ff <= PROD_BITS'(w_re * b_im);
         p_ir_ff <= PROD_BITS'(w_im * b_re);
         ar_ff <= a_re;
         ai_ff <= a_im;
      end
      if (ctl.sum_en) begin
         tr_ff <= sat_word(sr);
         ti_ff <= sat_word(si);
         ar2_ff <= ar_ff;
         ai2_ff <= ai_ff;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rfft_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module rfft_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   input  wire rfft_pkg::cmd_type                 cmd,
   output logic                                   cmd_pop,
   input  wire logic [rfft_pkg::L_BITS-1:0]       eff_l,
   input  wire logic                              inverse,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [rfft_pkg::WORD_BITS-1:0]  rsp_re,
   output logic signed [rfft_pkg::WORD_BITS-1:0]  rsp_im,
   output logic [rfft_pkg::AW-1:0]                rsp_index
);
   import rfft_pkg::*;

   back_state_type state_ff, state_in;
   logic [2*WORD_BITS-1:0] mem [1 << AW];
   logic [2*WORD_BITS-1:0] rda_ff, rdb_ff, wd;
   logic [AW-1:0]          ra, rb, wa, k, q, j, n_m1;
   logic                   we;
   logic [L_BITS-1:0]      stage_ff, stage_in, sm1;
   logic [TW_AW-1:0]       bfly_ff, bfly_in, last_bfly, ti;
   logic [AW-1:0]          scan_ff, scan_in;
   logic                   rsp_valid_ff, rsp_load;
   logic signed [WORD_BITS-1:0]    rsp_re_ff, rsp_im_ff;
   logic [AW-1:0]                  rsp_index_ff;
   logic signed [TWIDDLE_BITS:0]   tw_re_ff, tw_im_ff;
   logic signed [TWIDDLE_BITS-1:0] tc, ts;
   logic signed [WORD_BITS:0]      sc_re, sc_im;
   logic signed [WORD_BITS-1:0]    top_re, top_im, bot_re, bot_im;
   logic                   out_free, last_b, last_s;
   bfly_ctl_type           ctl;

   always_comb begin
      sm1 = stage_ff - L_BITS'(1);
      j = AW'(bfly_ff) & AW'((11'd1 << sm1) - 11'd1);
      k = AW'((AW'(bfly_ff) >> sm1) << stage_ff) | j;
      q = k | AW'(11'd1 << sm1);
      ti = TW_AW'(j << (L_BITS'(AW) - stage_ff));
      last_bfly = TW_AW'((11'd1 << (eff_l - L_BITS'(1))) - 11'd1);
      n_m1 = AW'((11'd1 << eff_l) - 11'd1);
      last_b = (bfly_ff == last_bfly);
      last_s = (stage_ff == eff_l);
      out_free = !rsp_valid_ff || !rsp_stall;
      tc = TW_COS[ti*TWIDDLE_BITS +: TWIDDLE_BITS];
      ts = TW_SIN[ti*TWIDDLE_BITS +: TWIDDLE_BITS];
      sc_re = ((WORD_BITS+1)'(signed'(rda_ff[2*WORD_BITS-1:WORD_BITS]))
               + ((WORD_BITS+1)'(1) <<< (eff_l - L_BITS'(1)))) >>> eff_l;
      sc_im = ((WORD_BITS+1)'(signed'(rda_ff[WORD_BITS-1:0]))
               + ((WORD_BITS+1)'(1) <<< (eff_l - L_BITS'(1)))) >>> eff_l;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op == OP_RUN) begin
               state_in = ST_BF_READ;
            end else if (cmd_valid && cmd.op == OP_READ && out_free) begin
               state_in = ST_RD_WAIT;
            end
         end
         ST_RD_WAIT: state_in = ST_IDLE;
         ST_BF_READ: state_in = ST_BF_MUL;
         ST_BF_MUL:  state_in = ST_BF_SUM;
         ST_BF_SUM:  state_in = ST_BF_WR_A;
         ST_BF_WR_A: state_in = ST_BF_WR_B;
         ST_BF_WR_B: begin
            if (last_b && last_s) begin
               state_in = inverse ? ST_SC_READ : ST_IDLE;
            end else begin
               state_in = ST_BF_READ;
            end
         end
         ST_SC_READ: state_in = ST_SC_WR;
         ST_SC_WR:   state_in = (scan_ff == n_m1) ? ST_IDLE : ST_SC_READ;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      we = 1'b0;
      wa = k;
      wd = {top_re, top_im};
      ra = k;
      rb = q;
      ctl = '0;
      rsp_load = 1'b0;
      stage_in = stage_ff;
      bfly_in = bfly_ff;
      scan_in = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            ra = cmd.addr;
            if (cmd_valid) begin
               case (cmd.op)
                  OP_LOAD: begin
                     cmd_pop = 1'b1;
                     we = 1'b1;
                     wa = cmd.addr;
                     wd = {WORD_BITS'(cmd.re), WORD_BITS'(cmd.im)};
                  end
                  OP_RUN: begin
                     cmd_pop = 1'b1;
                     stage_in = L_BITS'(1);
                     bfly_in = '0;
                  end
                  default: cmd_pop = out_free;
               endcase
            end
         end
         ST_RD_WAIT: rsp_load = 1'b1;
         ST_BF_MUL:  ctl.mul_en = 1'b1;
         ST_BF_SUM:  ctl.sum_en = 1'b1;
         ST_BF_WR_A: we = 1'b1;
         ST_BF_WR_B: begin
            we = 1'b1;
            wa = q;
            wd = {bot_re, bot_im};
            scan_in = '0;
            if (last_b) begin
               bfly_in = '0;
               stage_in = stage_ff + L_BITS'(1);
            end else begin
               bfly_in = bfly_ff + TW_AW'(1);
            end
         end
         ST_SC_READ: ra = scan_ff;
         ST_SC_WR: begin
            we = 1'b1;
            wa = scan_ff;
            wd = {sc_re[WORD_BITS-1:0], sc_im[WORD_BITS-1:0]};
            scan_in = scan_ff + AW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rda_ff <= mem[ra];
      rdb_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      tw_re_ff <= (TWIDDLE_BITS+1)'(tc);
      tw_im_ff <= inverse ? -(TWIDDLE_BITS+1)'(ts) : (TWIDDLE_BITS+1)'(ts);
      if (state_ff == ST_IDLE && cmd_pop && cmd.op == OP_READ) begin
         rsp_index_ff <= cmd.index;
      end
      if (rsp_load) begin
         rsp_re_ff <= rda_ff[2*WORD_BITS-1:WORD_BITS];
         rsp_im_ff <= rda_ff[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= L_BITS'(1);
         bfly_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         bfly_ff <= bfly_in;
         scan_ff <= scan_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   rfft_bfly u_bfly (
      .clock  (clock),
      .ctl    (ctl),
      .a_re   (rda_ff[2*WORD_BITS-1:WORD_BITS]),
      .a_im   (rda_ff[WORD_BITS-1:0]),
      .b_re   (rdb_ff[2*WORD_BITS-1:WORD_BITS]),
      .b_im   (rdb_ff[WORD_BITS-1:0]),
      .w_re   (tw_re_ff),
      .w_im   (tw_im_ff),
      .top_re (top_re),
      .top_im (top_im),
      .bot_re (bot_re),
      .bot_im (bot_im)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_re = rsp_re_ff;
   assign rsp_im = rsp_im_ff;
   assign rsp_index = rsp_index_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == ST_IDLE)
      else $error("command taken outside idle");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RD_WAIT)
      else $error("result raised without a read");
   a_bfly_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BF_READ |-> stage_ff >= L_BITS'(1) && stage_ff <= eff_l
                                 && bfly_ff <= last_bfly)
      else $error("butterfly counters out of range");

endmodule
`default_nettype wire

[hw/rtl/radix2_complex_fft.sv]
`timescale 1ns / 1ps
`default_nettype none
// In-place radix-2 decimation-in-time FFT of N = 2^log2_size points in 27-bit
// fixed point. Load every index with func 0, start the transform with func 1,
// then read bins with func 2; only a read returns an item. Every butterfly of
// a run passes through a five-step sequence around the data store, whose
// single write port takes the two results on separate cycles; an inverse run
// adds a scaling pass over the store for the divide by N. A short command
// queue lets items be accepted while a run is in progress.
module radix2_complex_fft (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_func,
   input  wire logic [rfft_pkg::AW-1:0]               req_sample_index,
   input  wire logic signed [rfft_pkg::SAMPLE_BITS-1:0] req_sample_re,
   input  wire logic signed [rfft_pkg::SAMPLE_BITS-1:0] req_sample_im,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [rfft_pkg::WORD_BITS-1:0]      rsp_result_re,
   output logic signed [rfft_pkg::WORD_BITS-1:0]      rsp_result_im,
   output logic [rfft_pkg::AW-1:0]                    rsp_result_index,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic                                  csr_index,
   input  wire logic [3:0]                            csr_wdata
);
   import rfft_pkg::*;

   logic [3:0]        log2_ff;
   logic              inv_ff;
   logic [L_BITS-1:0] eff_l;
   logic              cmd_valid, cmd_pop;
   cmd_type           cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= 4'd10;
         inv_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == 1'b0) begin
            log2_ff <= csr_wdata;
         end else begin
            inv_ff <= csr_wdata[0];
         end
      end
   end

   always_comb begin
      if (log2_ff == 4'd0) begin
         eff_l = L_BITS'(1);
      end else if (log2_ff > 4'(MAX_LOG2)) begin
         eff_l = L_BITS'(MAX_LOG2);
      end else begin
         eff_l = L_BITS'(log2_ff);
      end
   end

   rfft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_index (req_sample_index),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .eff_l            (eff_l),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   rfft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .eff_l     (eff_l),
      .inverse   (inv_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_re    (rsp_result_re),
      .rsp_im    (rsp_result_im),
      .rsp_index (rsp_result_index)
   );

endmodule
`default_nettype wire
